// ----- design/sjf_round_robin_cpu_scheduler_assert.svh -----
// Assertion macros shared by the checker. Each expects clk in scope; the first two also need rst.
`ifndef SJF_ROUND_ROBIN_CPU_SCHEDULER_ASSERT_SVH
`define SJF_ROUND_ROBIN_CPU_SCHEDULER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define SJFRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, ignored while reset is held.
`define SJFRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication that is also checked across reset.
`define SJFRR_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ----- design/sjfrr_pkg.sv -----
package sjfrr_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned CMD_W       = 1;
  localparam int unsigned JOB_ID_W    = 8;
  localparam int unsigned JOB_BURST_W = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned SLICE_W     = 16;

  // Defaults of the top-level parameters.
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_ID_BITS     = 8;
  localparam int unsigned DEF_BURST_BITS  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RAN      = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY_MODE = 1'b0,
    REG_TIME_SLICE  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    POLICY_SJF = 1'b0,
    POLICY_RR  = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_JOB  = 2'd1,
    KIND_IDLE = 2'd2
  } entry_kind_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;      // take the pushed job
    logic shift;     // take the job of the next cell
    logic occupied;  // cell holds a waiting job
  } cell_ctl_t;

endpackage

// ----- design/sjfrr_if.sv -----
interface sjfrr_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [sjfrr_pkg::CMD_W-1:0]       command;
  logic [sjfrr_pkg::JOB_ID_W-1:0]    job_id;
  logic [sjfrr_pkg::JOB_BURST_W-1:0] job_burst;

  modport source (output valid, command, job_id, job_burst, input ready);
  modport sink (input valid, command, job_id, job_burst, output ready);
endinterface

interface sjfrr_result_if;
  logic                           valid;
  logic                           ready;
  logic [sjfrr_pkg::STATUS_W-1:0]  status;
  logic [sjfrr_pkg::JOB_ID_W-1:0]  running_id;
  logic                           job_finished;
  logic                           job_preempted;
  logic                           record_valid;
  logic                           record_is_idle;
  logic [sjfrr_pkg::COUNT_W-1:0]   ready_count;

  modport source (output valid, status, running_id, job_finished, job_preempted,
                  record_valid, record_is_idle, ready_count, input ready);
  modport sink (input valid, status, running_id, job_finished, job_preempted,
                record_valid, record_is_idle, ready_count, output ready);
endinterface

interface sjfrr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sjfrr_pkg::CFG_IDX_W-1:0]  index;
  logic [sjfrr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/sjfrr_cell.sv -----
module sjfrr_cell #(
  parameter int unsigned ID_BITS    = sjfrr_pkg::DEF_ID_BITS,
  parameter int unsigned BURST_BITS = sjfrr_pkg::DEF_BURST_BITS,
  parameter int unsigned IDX_BITS   = 4,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk,
  input  sjfrr_pkg::cell_ctl_t  ctl,
  input  logic [ID_BITS-1:0]    push_id,
  input  logic [BURST_BITS-1:0] push_burst,
  input  logic [ID_BITS-1:0]    nxt_id,
  input  logic [BURST_BITS-1:0] nxt_burst,
  output logic [ID_BITS-1:0]    id,
  output logic [BURST_BITS-1:0] burst,
  input  logic                  in_found,
  input  logic [IDX_BITS-1:0]   in_idx,
  input  logic [ID_BITS-1:0]    in_id,
  input  logic [BURST_BITS-1:0] in_burst,
  output logic                  out_found,
  output logic [IDX_BITS-1:0]   out_idx,
  output logic [ID_BITS-1:0]    out_id,
  output logic [BURST_BITS-1:0] out_burst
);

  logic take_own;

  // Strict less-than keeps the older job on a tie.
  assign take_own = ctl.occupied && (!in_found || (burst < in_burst));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id    <= push_id;
      burst <= push_burst;
    end else if (ctl.shift) begin
      id    <= nxt_id;
      burst <= nxt_burst;
    end
  end

  // The running minimum moves one cell to the right on every clock.
  always_ff @(posedge clk) begin
    out_found <= in_found | ctl.occupied;
    if (take_own) begin
      out_idx   <= IDX_BITS'(INDEX);
      out_id    <= id;
      out_burst <= burst;
    end else begin
      out_idx   <= in_idx;
      out_id    <= in_id;
      out_burst <= in_burst;
    end
  end

endmodule

// ----- design/sjf_round_robin_cpu_scheduler.sv -----
// Channel  Dir  Beat carries
// -------  ---  -----------------------------------------------------------
// cmd      in   command, job_id, job_burst
// result   out  status, running_id, job_finished, job_preempted,
//               record_valid, record_is_idle, ready_count
// cfg      in   index, data (always ready)
//
// An arrive or a tick that dispatches nothing passes S_EXEC and S_EMIT; a
// round robin dispatch passes S_TAKE first. A shortest-job dispatch waits in
// S_SCAN before S_TAKE while the minimum search ripples one cell per cycle
// down the cell chain. cmd takes one beat at a time and is ready again after
// the result is registered, even while that result still waits on the sink.
// A stalled result holds the sequencer only when the next result is due.
// rst is synchronous and clears the queue count, the running job and config.
module sjf_round_robin_cpu_scheduler #(
  parameter int unsigned QUEUE_DEPTH = sjfrr_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = sjfrr_pkg::DEF_ID_BITS,
  parameter int unsigned BURST_BITS  = sjfrr_pkg::DEF_BURST_BITS
) (
  input logic           clk,
  input logic           rst,
  sjfrr_cmd_if.sink     cmd,
  sjfrr_result_if.source result,
  sjfrr_cfg_if.sink     cfg
);

  localparam int unsigned IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW       = sjfrr_pkg::SLICE_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TAKE = 5'b00100,
    S_EXEC = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                   state;
  logic [IDX_BITS-1:0]      scan_cnt;
  logic [CNT_BITS-1:0]      fill;
  logic                     busy;
  logic [ID_BITS-1:0]       cur_id;
  logic [BURST_BITS-1:0]    cur_left;
  logic [SW-1:0]            slice_used;
  sjfrr_pkg::entry_kind_t   last_kind;
  logic [ID_BITS-1:0]       last_id;
  sjfrr_pkg::policy_t       policy_mode;
  logic [SW-1:0]            time_slice;

  sjfrr_pkg::cmd_t          lat_cmd;
  logic [ID_BITS-1:0]       lat_id;
  logic [BURST_BITS-1:0]    lat_burst;

  sjfrr_pkg::status_t       res_status;
  logic [ID_BITS-1:0]       res_id;
  logic                     res_fin;
  logic                     res_pre;
  logic                     res_rec;
  logic                     res_rec_idle;

  // Cell chain wiring; entry 0 of the scan arrays feeds the first cell.
  logic [ID_BITS-1:0]       cell_id    [QUEUE_DEPTH];
  logic [BURST_BITS-1:0]    cell_burst [QUEUE_DEPTH];
  logic                     scan_found [QUEUE_DEPTH+1];
  logic [IDX_BITS-1:0]      scan_idx   [QUEUE_DEPTH+1];
  logic [ID_BITS-1:0]       scan_id    [QUEUE_DEPTH+1];
  logic [BURST_BITS-1:0]    scan_burst [QUEUE_DEPTH+1];

  logic                     push_en;
  logic                     shift_en;
  logic [ID_BITS-1:0]       push_id;
  logic [BURST_BITS-1:0]    push_burst;
  logic [IDX_BITS-1:0]      take_idx;
  logic [ID_BITS-1:0]       sel_id;
  logic [BURST_BITS-1:0]    sel_burst;

  logic [63:0]              id_wide;
  logic [63:0]              burst_wide;
  logic [63:0]              rid_wide;
  logic [63:0]              cnt_wide;
  logic [BURST_BITS-1:0]    left_next;
  logic [SW-1:0]            slice_next;
  logic [SW-1:0]            ts_eff;
  logic                     do_fin;
  logic                     do_pre;
  logic                     arr_ok;
  logic                     in_fire;

  assign cmd.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign in_fire    = cmd.valid && cmd.ready;
  assign id_wide    = 64'(cmd.job_id);
  assign burst_wide = 64'(cmd.job_burst);
  assign rid_wide   = 64'(res_id);
  assign cnt_wide   = 64'(fill);

  assign scan_found[0] = 1'b0;
  assign scan_idx[0]   = '0;
  assign scan_id[0]    = '0;
  assign scan_burst[0] = '0;

  always_comb begin
    left_next  = (cur_left != '0) ? cur_left - BURST_BITS'(1) : cur_left;
    slice_next = (slice_used == {SW{1'b1}}) ? slice_used : slice_used + SW'(1);
    ts_eff     = (time_slice == '0) ? SW'(1) : time_slice;
    do_fin     = (left_next == '0);
    do_pre     = !do_fin && (policy_mode == sjfrr_pkg::POLICY_RR) && (slice_next >= ts_eff);
    arr_ok     = (lat_burst != '0) &&
                 ((CNT_BITS+1)'(fill) + (CNT_BITS+1)'(busy) < (CNT_BITS+1)'(QUEUE_DEPTH));
  end

  always_comb begin
    if (policy_mode == sjfrr_pkg::POLICY_RR) begin
      take_idx  = '0;
      sel_id    = cell_id[0];
      sel_burst = cell_burst[0];
    end else begin
      take_idx  = scan_idx[QUEUE_DEPTH];
      sel_id    = scan_id[QUEUE_DEPTH];
      sel_burst = scan_burst[QUEUE_DEPTH];
    end
    shift_en   = (state == S_TAKE);
    push_en    = 1'b0;
    push_id    = lat_id;
    push_burst = lat_burst;
    if (state == S_EXEC) begin
      if (lat_cmd == sjfrr_pkg::CMD_ARRIVE) begin
        push_en = arr_ok;
      end else if (busy && do_pre && (fill < CNT_BITS'(QUEUE_DEPTH))) begin
        push_en    = 1'b1;
        push_id    = cur_id;
        push_burst = left_next;
      end
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sjfrr_pkg::cell_ctl_t  ctl;
    logic [ID_BITS-1:0]    nxt_id;
    logic [BURST_BITS-1:0] nxt_burst;

    assign ctl.load     = push_en && (fill == CNT_BITS'(i));
    assign ctl.shift    = shift_en && (IDX_BITS'(i) >= take_idx);
    assign ctl.occupied = (CNT_BITS'(i) < fill);

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nxt_id    = push_id;
      assign nxt_burst = push_burst;
    end else begin : g_body
      assign nxt_id    = cell_id[i+1];
      assign nxt_burst = cell_burst[i+1];
    end

    sjfrr_cell #(
      .ID_BITS   (ID_BITS),
      .BURST_BITS(BURST_BITS),
      .IDX_BITS  (IDX_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .push_id   (push_id),
      .push_burst(push_burst),
      .nxt_id    (nxt_id),
      .nxt_burst (nxt_burst),
      .id        (cell_id[i]),
      .burst     (cell_burst[i]),
      .in_found  (scan_found[i]),
      .in_idx    (scan_idx[i]),
      .in_id     (scan_id[i]),
      .in_burst  (scan_burst[i]),
      .out_found (scan_found[i+1]),
      .out_idx   (scan_idx[i+1]),
      .out_id    (scan_id[i+1]),
      .out_burst (scan_burst[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= sjfrr_pkg::POLICY_SJF;
      time_slice  <= SW'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (sjfrr_pkg::cfg_reg_t'(cfg.index))
        sjfrr_pkg::REG_POLICY_MODE: policy_mode <= sjfrr_pkg::policy_t'(cfg.data[0]);
        sjfrr_pkg::REG_TIME_SLICE:  time_slice  <= cfg.data[SW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scan_cnt     <= '0;
      fill         <= '0;
      busy         <= 1'b0;
      cur_id       <= '0;
      cur_left     <= '0;
      slice_used   <= '0;
      last_kind    <= sjfrr_pkg::KIND_NONE;
      last_id      <= '0;
      result.valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            lat_cmd      <= sjfrr_pkg::cmd_t'(cmd.command);
            lat_id       <= id_wide[ID_BITS-1:0];
            lat_burst    <= burst_wide[BURST_BITS-1:0];
            res_rec      <= 1'b0;
            res_rec_idle <= 1'b0;
            scan_cnt     <= '0;
            if ((cmd.command == sjfrr_pkg::CMD_TICK) && !busy && (fill != '0)) begin
              state <= (policy_mode == sjfrr_pkg::POLICY_RR) ? S_TAKE : S_SCAN;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + IDX_BITS'(1);
          if (scan_cnt == IDX_BITS'(QUEUE_DEPTH - 1)) begin
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          cur_id     <= sel_id;
          cur_left   <= sel_burst;
          busy       <= 1'b1;
          slice_used <= '0;
          fill       <= fill - CNT_BITS'(1);
          // A round robin job that follows itself adds no new run entry.
          if (!((policy_mode == sjfrr_pkg::POLICY_RR) &&
                (last_kind == sjfrr_pkg::KIND_JOB) && (last_id == sel_id))) begin
            res_rec   <= 1'b1;
            last_kind <= sjfrr_pkg::KIND_JOB;
            last_id   <= sel_id;
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          res_id  <= '0;
          res_fin <= 1'b0;
          res_pre <= 1'b0;
          if (lat_cmd == sjfrr_pkg::CMD_ARRIVE) begin
            if (arr_ok) begin
              res_status <= sjfrr_pkg::ST_ACCEPTED;
              fill       <= fill + CNT_BITS'(1);
            end else begin
              res_status <= sjfrr_pkg::ST_REJECTED;
            end
          end else if (busy) begin
            res_status <= sjfrr_pkg::ST_RAN;
            res_id     <= cur_id;
            cur_left   <= left_next;
            slice_used <= slice_next;
            if (do_fin) begin
              res_fin <= 1'b1;
              busy    <= 1'b0;
              cur_id  <= '0;
            end else if (do_pre) begin
              res_pre <= 1'b1;
              busy    <= 1'b0;
              if (fill < CNT_BITS'(QUEUE_DEPTH)) begin
                fill <= fill + CNT_BITS'(1);
              end
            end
          end else begin
            res_status <= sjfrr_pkg::ST_IDLE;
            if (last_kind != sjfrr_pkg::KIND_IDLE) begin
              res_rec      <= 1'b1;
              res_rec_idle <= 1'b1;
              last_kind    <= sjfrr_pkg::KIND_IDLE;
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!result.valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!result.valid || result.ready)) begin
      result.status         <= res_status;
      result.running_id     <= rid_wide[sjfrr_pkg::JOB_ID_W-1:0];
      result.job_finished   <= res_fin;
      result.job_preempted  <= res_pre;
      result.record_valid   <= res_rec;
      result.record_is_idle <= res_rec_idle;
      result.ready_count    <= cnt_wide[sjfrr_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ----- design/sjfrr_checker.sv -----
`include "sjf_round_robin_cpu_scheduler_assert.svh"

module sjfrr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sjfrr_pkg::STATUS_W-1:0] status,
  input logic                          job_finished,
  input logic                          job_preempted,
  input logic                          record_valid,
  input logic                          record_is_idle
);

  // A result beat that is not taken stays up with the same status.
  `SJFRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

  // The scheduler works on one command at a time.
  `SJFRR_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // Reset drops any pending result beat.
  `SJFRR_ASSERT_NEXT_ANY(a_reset_clears, rst, !out_valid)

  // An idle marker only comes with an idle tick, and a preempted job did not finish.
  `SJFRR_ASSERT_NOW(a_flags_consistent,
    out_valid && (record_is_idle || job_preempted),
    (!record_is_idle || (record_valid && (status == sjfrr_pkg::ST_IDLE))) &&
    (!job_preempted || ((status == sjfrr_pkg::ST_RAN) && !job_finished)))

endmodule

bind sjf_round_robin_cpu_scheduler sjfrr_checker u_sjfrr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (cmd.valid),
  .in_ready      (cmd.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .status        (result.status),
  .job_finished  (result.job_finished),
  .job_preempted (result.job_preempted),
  .record_valid  (result.record_valid),
  .record_is_idle(result.record_is_idle)
);
